[rtl/core/ia_pkg.sv]
package ia_pkg;

	localparam int unsigned WORD  = 128;
	localparam int unsigned NSTEP = 128;
	localparam int unsigned LIMB  = 32;
	localparam int unsigned NLIMB = WORD / LIMB;

	// operation codes
	localparam logic [3:0] OP_UADD = 4'd0;
	localparam logic [3:0] OP_USUB = 4'd1;
	localparam logic [3:0] OP_UMUL = 4'd2;
	localparam logic [3:0] OP_UDIV = 4'd3;
	localparam logic [3:0] OP_UMOD = 4'd4;
	localparam logic [3:0] OP_SADD = 4'd5;
	localparam logic [3:0] OP_SSUB = 4'd6;
	localparam logic [3:0] OP_SMUL = 4'd7;
	localparam logic [3:0] OP_SDIV = 4'd8;
	localparam logic [3:0] OP_SMOD = 4'd9;

	// error codes
	localparam logic [1:0] ERR_NONE = 2'd0;
	localparam logic [1:0] ERR_OVF  = 2'd1;
	localparam logic [1:0] ERR_DIV0 = 2'd2;

	typedef struct packed {
		logic [3:0]      op;
		logic            chk;
		logic            sa;
		logic            sb;
		logic            bz;
		logic [WORD-1:0] res;   // add/sub result, later low product
		logic            flag;  // add/sub overflow, later product above 128 bits
		logic [WORD-1:0] n;     // dividend bits still to shift in, or multiplicand
		logic [WORD-1:0] d;     // divisor, or multiplier
		logic [WORD-1:0] rem;
		logic [WORD-1:0] quo;
	} stage_t;

	// one restoring division step
	function automatic stage_t div_step(stage_t s);
		stage_t        o;
		logic [WORD:0] rt;
		logic [WORD:0] df;
		o = s;
		rt = {s.rem, s.n[WORD-1]};
		df = rt - {1'b0, s.d};
		o.n = {s.n[WORD-2:0], 1'b0};
		if (!df[WORD]) begin
			o.rem = df[WORD-1:0];
			o.quo = {s.quo[WORD-2:0], 1'b1};
		end else begin
			o.rem = rt[WORD-1:0];
			o.quo = {s.quo[WORD-2:0], 1'b0};
		end
		return o;
	endfunction

endpackage

[rtl/core/ia_req_if.sv]
interface ia_req_if;
	logic        valid;
	logic        ready;
	logic [3:0]  action;
	logic        check_overflow;
	logic [63:0] a_high;
	logic [63:0] a_low;
	logic [63:0] b_high;
	logic [63:0] b_low;

	modport source (output valid, action, check_overflow, a_high, a_low, b_high, b_low,
		input ready);
	modport sink (input valid, action, check_overflow, a_high, a_low, b_high, b_low,
		output ready);
endinterface

[rtl/core/ia_rsp_if.sv]
interface ia_rsp_if;
	logic        valid;
	logic        ready;
	logic [63:0] result_high;
	logic [63:0] result_low;
	logic [1:0]  error_code;

	modport source (output valid, result_high, result_low, error_code, input ready);
	modport sink (input valid, result_high, result_low, error_code, output ready);
endinterface

[rtl/core/int128_arith_unit.sv]
// 128-bit integer arithmetic unit.
// req carries an operation code, an overflow-check bit and two 128-bit
// operands in high and low halves; rsp returns one result item per request
// item, the 128-bit result and an error code, in request order.
// The unit is a single pipeline: an input register, an operand stage
// (magnitudes, add/subtract, zero test), 128 restoring division stages of
// one quotient bit each, and an output stage for sign correction and error
// selection. Multiplication runs beside the first division stages as 32x32
// partial products summed over three further stages.
// One item is taken every cycle while rsp does not stall.
// The whole pipeline advances together whenever the output register is
// empty or being taken; when rsp stalls, every stage holds and req.ready
// falls, so nothing is lost or repeated.
// Reset clears all valid bits; the pipeline is empty afterwards and
// accepts at once.
module int128_arith_unit
	import ia_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	ia_req_if.sink   req,
	ia_rsp_if.source rsp
);

	localparam int unsigned MUL_STAGE = 4;

	logic en;

	logic            vld_s1;
	logic [3:0]      op_s1;
	logic            chk_s1;
	logic [WORD-1:0] a_s1;
	logic [WORD-1:0] b_s1;

	stage_t pipe [0:NSTEP];
	stage_t nxt  [0:NSTEP];
	logic   vld  [0:NSTEP];

	logic [63:0]       pp_s3   [0:NLIMB-1][0:NLIMB-1];
	logic [159:0]      row_s4  [0:NLIMB-1];
	logic [191:0]      half_s5 [0:1];
	logic [2*WORD-1:0] prod;

	logic            vld_q;
	logic [WORD-1:0] res_q;
	logic [1:0]      err_q;

	assign en        = !vld_q || rsp.ready;
	assign req.ready = en;

	// operand stage
	always_comb begin
		logic [WORD-1:0] absa;
		logic [WORD-1:0] absb;
		logic            sgn;
		logic            sub;
		absa = a_s1[WORD-1] ? (~a_s1 + 1'b1) : a_s1;
		absb = b_s1[WORD-1] ? (~b_s1 + 1'b1) : b_s1;
		sgn  = (op_s1 == OP_SMUL) || (op_s1 == OP_SDIV) || (op_s1 == OP_SMOD);
		sub  = (op_s1 == OP_USUB) || (op_s1 == OP_SSUB);
		nxt[0].op  = op_s1;
		nxt[0].chk = chk_s1;
		nxt[0].sa  = a_s1[WORD-1];
		nxt[0].sb  = b_s1[WORD-1];
		nxt[0].bz  = (b_s1 == '0);
		nxt[0].res = sub ? (a_s1 - b_s1) : (a_s1 + b_s1);
		if (op_s1 == OP_SADD)
			nxt[0].flag = (a_s1[WORD-1] == b_s1[WORD-1]) &&
				(nxt[0].res[WORD-1] != a_s1[WORD-1]);
		else
			nxt[0].flag = (a_s1[WORD-1] != b_s1[WORD-1]) &&
				(nxt[0].res[WORD-1] != a_s1[WORD-1]);
		nxt[0].n   = sgn ? absa : a_s1;
		nxt[0].d   = sgn ? absb : b_s1;
		nxt[0].rem = '0;
		nxt[0].quo = '0;
	end

	// division steps, with the product dropped in once it is summed
	assign prod = {64'd0, half_s5[0]} + {half_s5[1], 64'd0};

	for (genvar k = 1; k <= NSTEP; k++) begin : g_step
		always_comb begin
			nxt[k] = div_step(pipe[k-1]);
			if (k == MUL_STAGE &&
				(pipe[k-1].op == OP_UMUL || pipe[k-1].op == OP_SMUL)) begin
				nxt[k].res  = prod[WORD-1:0];
				nxt[k].flag = |prod[2*WORD-1:WORD];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			for (int k = 0; k <= NSTEP; k++)
				vld[k] <= 1'b0;
			vld_q <= 1'b0;
		end else if (en) begin
			vld_s1 <= req.valid;
			vld[0] <= vld_s1;
			for (int k = 1; k <= NSTEP; k++)
				vld[k] <= vld[k-1];
			vld_q <= vld[NSTEP];
		end
	end

	// payload: advance every stage together
	always_ff @(posedge clk) begin
		if (en) begin
			op_s1  <= req.action;
			chk_s1 <= req.check_overflow;
			a_s1   <= {req.a_high, req.a_low};
			b_s1   <= {req.b_high, req.b_low};
			for (int k = 0; k <= NSTEP; k++)
				pipe[k] <= nxt[k];
			for (int i = 0; i < NLIMB; i++)
				for (int j = 0; j < NLIMB; j++)
					pp_s3[i][j] <= pipe[0].n[LIMB*i +: LIMB] * pipe[0].d[LIMB*j +: LIMB];
			for (int i = 0; i < NLIMB; i++)
				row_s4[i] <= {96'd0, pp_s3[i][0]} + {64'd0, pp_s3[i][1], 32'd0} +
					{32'd0, pp_s3[i][2], 64'd0} + {pp_s3[i][3], 96'd0};
			half_s5[0] <= {32'd0, row_s4[0]} + {row_s4[1], 32'd0};
			half_s5[1] <= {32'd0, row_s4[2]} + {row_s4[3], 32'd0};
		end
	end

	// output stage: sign correction and error selection
	always_ff @(posedge clk) begin
		stage_t          s;
		logic [WORD-1:0] neg;
		logic [WORD-1:0] r;
		logic [1:0]      e;
		s   = pipe[NSTEP];
		neg = ~((s.op == OP_SMUL) ? s.res : s.quo) + 1'b1;
		r   = '0;
		e   = ERR_NONE;
		unique case (s.op)
			OP_UADD, OP_USUB: r = s.res;
			OP_SADD, OP_SSUB: begin
				r = s.res;
				if (s.flag) e = ERR_OVF;
			end
			OP_UMUL: begin
				r = s.res;
				if (s.chk && s.flag) e = ERR_OVF;
			end
			OP_SMUL: begin
				if (s.flag) e = ERR_OVF;
				else if (s.sa != s.sb) begin
					r = neg;
					if (s.res[WORD-1] && |s.res[WORD-2:0]) e = ERR_OVF;
				end else begin
					r = s.res;
					if (s.res[WORD-1]) e = ERR_OVF;
				end
			end
			OP_UDIV: begin
				r = s.quo;
				if (s.bz) e = ERR_DIV0;
			end
			OP_UMOD, OP_SMOD: begin
				r = s.rem;
				if (s.bz) e = ERR_DIV0;
			end
			OP_SDIV: begin
				if (s.bz) e = ERR_DIV0;
				else if (s.sa != s.sb) r = neg;
				else begin
					r = s.quo;
					if (s.quo[WORD-1]) e = ERR_OVF;
				end
			end
			default: r = '0;
		endcase
		if (en) begin
			res_q <= (e != ERR_NONE) ? '0 : r;
			err_q <= e;
		end
	end

	assign rsp.valid       = vld_q;
	assign rsp.result_high = res_q[WORD-1:64];
	assign rsp.result_low  = res_q[63:0];
	assign rsp.error_code  = err_q;

`ifndef ASSERT_OFF
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid && rsp.error_code != ERR_NONE |-> res_q == '0)
		else $error("error item carries a nonzero result");

	a_code_range: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> rsp.error_code != 2'd3)
		else $error("undefined error code");

	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		req.ready == (!rsp.valid || rsp.ready))
		else $error("input ready does not follow output stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		vld[NSTEP] && rsp.valid && !rsp.ready |=> vld[NSTEP] && rsp.valid)
		else $error("item dropped during stall");
`endif

endmodule

[tb/sv/ia_tb_pkg.sv]
package ia_tb_pkg;
	import ia_pkg::*;

	typedef struct {
		logic [3:0]   action;
		logic         chk;
		logic [127:0] a;
		logic [127:0] b;
	} arith_req_t;

	typedef struct {
		logic [127:0] value;
		logic [1:0]   err;
	} arith_rsp_t;

	// restoring long division of magnitudes, divisor nonzero
	function automatic void long_divide(input logic [127:0] n, input logic [127:0] d,
		output logic [127:0] q, output logic [127:0] r);
		logic [128:0] acc;
		acc = '0;
		q = '0;
		for (int k = 127; k >= 0; k--) begin
			acc = {acc[127:0], n[k]};
			if (acc >= {1'b0, d}) begin
				acc = acc - {1'b0, d};
				q[k] = 1'b1;
			end
		end
		r = acc[127:0];
	endfunction

	// expected result of one request item
	function automatic arith_rsp_t arith_result(arith_req_t t);
		arith_rsp_t   o;
		logic [255:0] prod;
		logic [127:0] ma, mb, q, r, sum;
		logic         sa, sb;
		sa = t.a[127];
		sb = t.b[127];
		ma = sa ? -t.a : t.a;
		mb = sb ? -t.b : t.b;
		o.value = '0;
		o.err = ERR_NONE;
		case (t.action)
			OP_UADD: o.value = t.a + t.b;
			OP_USUB: o.value = t.a - t.b;
			OP_UMUL: begin
				prod = {128'd0, t.a} * {128'd0, t.b};
				o.value = prod[127:0];
				if (t.chk && prod[255:128] != 0) o.err = ERR_OVF;
			end
			OP_UDIV, OP_UMOD: begin
				if (t.b == 0) o.err = ERR_DIV0;
				else begin
					long_divide(t.a, t.b, q, r);
					o.value = (t.action == OP_UDIV) ? q : r;
				end
			end
			OP_SADD: begin
				sum = t.a + t.b;
				o.value = sum;
				if (sa == sb && sum[127] != sa) o.err = ERR_OVF;
			end
			OP_SSUB: begin
				sum = t.a - t.b;
				o.value = sum;
				if (sa != sb && sum[127] != sa) o.err = ERR_OVF;
			end
			OP_SMUL: begin
				prod = {128'd0, ma} * {128'd0, mb};
				if (prod[255:128] != 0) o.err = ERR_OVF;
				else if (sa != sb) begin
					if (prod[127] && prod[126:0] != 0) o.err = ERR_OVF;
					o.value = -prod[127:0];
				end else begin
					if (prod[127]) o.err = ERR_OVF;
					o.value = prod[127:0];
				end
			end
			OP_SDIV, OP_SMOD: begin
				if (t.b == 0) o.err = ERR_DIV0;
				else begin
					long_divide(ma, mb, q, r);
					if (t.action == OP_SMOD) o.value = r;
					else if (sa != sb) o.value = -q;
					else begin
						o.value = q;
						if (q[127]) o.err = ERR_OVF;
					end
				end
			end
			default: ;
		endcase
		if (o.err != ERR_NONE) o.value = '0;
		return o;
	endfunction
endpackage

[tb/sv/testbench.sv]
module testbench;
	import ia_pkg::*;
	import ia_tb_pkg::*;

	localparam int LATENCY = 131;

	logic clk;
	logic arst_n;

	ia_req_if req ();
	ia_rsp_if rsp ();

	int128_arith_unit dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req.sink),
		.rsp   (rsp.source)
	);

	arith_req_t pending_items[$];
	arith_rsp_t expected_results[$];
	int         mismatches = 0;
	bit         stimulus_done = 1'b0;
	bit         calm_send = 1'b0;
	bit         calm_recv = 1'b0;
	int         hold_cycles;
	int         received = 0;

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
	end

	// pick an interesting 128-bit operand
	function automatic logic [127:0] pick_operand();
		logic [127:0] v;
		v = {$urandom, $urandom, $urandom, $urandom};
		case ($urandom_range(0, 9))
			0: v = '0;
			1: v = 128'd1;
			2: v = '1;
			3: v = {1'b1, 127'd0};
			4: v = {1'b0, {127{1'b1}}};
			5: v = v >> $urandom_range(1, 127);
			6: v = -(v >> $urandom_range(1, 127));
			7: v = {64'd0, v[63:0]};
			default: ;
		endcase
		return v;
	endfunction

	task automatic push_item(logic [3:0] act, logic chk, logic [127:0] a, logic [127:0] b);
		arith_req_t t;
		t.action = act;
		t.chk = chk;
		t.a = a;
		t.b = b;
		pending_items.push_back(t);
	endtask

	task automatic report_mismatch(string what, logic [127:0] got, logic [127:0] want);
		$display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
		mismatches++;
	endtask

	// fill the queue: directed corners then random items
	initial begin
		logic [127:0] mn, mx;
		mn = {1'b1, 127'd0};
		mx = {1'b0, {127{1'b1}}};
		push_item(OP_UADD, 1'b0, '1, 128'd1);
		push_item(OP_USUB, 1'b0, '0, 128'd1);
		push_item(OP_UMUL, 1'b1, {64'd1, 64'd0}, {64'd1, 64'd0});
		push_item(OP_UMUL, 1'b0, {64'd1, 64'd0}, {64'd1, 64'd0});
		push_item(OP_UMUL, 1'b1, '1, 128'd1);
		push_item(OP_UDIV, 1'b0, '1, 128'd3);
		push_item(OP_UDIV, 1'b0, '1, '0);
		push_item(OP_UMOD, 1'b0, '1, 128'd7);
		push_item(OP_UMOD, 1'b0, 128'd5, '0);
		push_item(OP_SADD, 1'b0, mx, 128'd1);
		push_item(OP_SADD, 1'b0, mn, '1);
		push_item(OP_SSUB, 1'b0, mn, 128'd1);
		push_item(OP_SSUB, 1'b0, mx, '1);
		push_item(OP_SMUL, 1'b0, {1'b1, 63'd0, 64'd0}, '1);
		push_item(OP_SMUL, 1'b0, {65'd0, {63{1'b1}}}, -128'd2);
		push_item(OP_SMUL, 1'b0, {2'b01, 126'd0}, 128'd2);
		push_item(OP_SMUL, 1'b0, {2'b01, 126'd0}, -128'd2);
		push_item(OP_SDIV, 1'b0, mn, '1);
		push_item(OP_SDIV, 1'b0, -128'd7, 128'd2);
		push_item(OP_SDIV, 1'b0, 128'd7, '0);
		push_item(OP_SMOD, 1'b0, -128'd7, 128'd2);
		push_item(OP_SMOD, 1'b0, mn, '0);
		push_item(4'd10, 1'b1, '1, '1);
		push_item(4'd15, 1'b0, '1, '1);
		for (int i = 0; i < 1030; i++)
			push_item($urandom_range(0, 15) < 14 ? 4'($urandom_range(0, 9))
				: 4'($urandom_range(10, 15)), 1'($urandom), pick_operand(),
				pick_operand());
	end

	// drive request items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req.valid <= 1'b0;
			req.action <= '0;
			req.check_overflow <= 1'b0;
			req.a_high <= '0;
			req.a_low <= '0;
			req.b_high <= '0;
			req.b_low <= '0;
		end else if (!req.valid || req.ready) begin
			if (pending_items.size() != 0 && (calm_send || $urandom_range(0, 99) >= 10)) begin
				arith_req_t t;
				t = pending_items.pop_front();
				expected_results.push_back(arith_result(t));
				req.valid <= 1'b1;
				req.action <= t.action;
				req.check_overflow <= t.chk;
				{req.a_high, req.a_low} <= t.a;
				{req.b_high, req.b_low} <= t.b;
			end else begin
				req.valid <= 1'b0;
				if (pending_items.size() == 0) stimulus_done <= 1'b1;
			end
		end
	end

	// calm stretch on both sides, then one long hold on the result side
	always @(posedge clk) begin
		calm_send <= (received >= 300 && received < 500);
		calm_recv <= (received >= 300 && received < 500);
	end

	// drive ready and check result items
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp.ready <= 1'b0;
			hold_cycles <= 0;
		end else begin
			if (rsp.valid && rsp.ready) begin
				received <= received + 1;
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected result item",
						{rsp.result_high, rsp.result_low}, '0);
				end else begin
					arith_rsp_t e;
					e = expected_results.pop_front();
					if (rsp.result_high != e.value[127:64])
						report_mismatch("result_high", rsp.result_high, e.value[127:64]);
					if (rsp.result_low != e.value[63:0])
						report_mismatch("result_low", rsp.result_low, e.value[63:0]);
					if (rsp.error_code != e.err)
						report_mismatch("error_code", rsp.error_code, e.err);
				end
			end
			if (received == 600 && hold_cycles == 0) hold_cycles <= 400;
			if (hold_cycles > 1) begin
				hold_cycles <= hold_cycles - 1;
				rsp.ready <= 1'b0;
			end else begin
				if (hold_cycles == 1) hold_cycles <= -1;
				rsp.ready <= calm_recv || $urandom_range(0, 99) >= 10;
			end
		end
	end

	initial begin
		wait (arst_n === 1'b1);
		wait (stimulus_done && expected_results.size() == 0);
		repeat (LATENCY + 20) @(posedge clk);
		if (mismatches == 0 && expected_results.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

	initial begin
		#400000;
		$display("TB_ERROR");
		$finish;
	end
endmodule
